/* design/plw_pkg.sv */
// plw_pkg: shared constants, tables and types of the polar led line pixel writer
// depends on nothing; used by plw_pixel_map, the top level and the testbench
`timescale 1ns / 1ps

package plw_pkg;

    localparam int ANGLES         = 240;
    localparam int RINGS          = 56;
    localparam int SUBLINES       = 7;
    localparam int LINE_BYTES     = 7;
    localparam int MAPPED_RINGS   = 56;
    localparam int TOTAL_SUBLINES = ANGLES * SUBLINES;
    localparam int ROW_BITS       = LINE_BYTES * 8;
    localparam int ROW_W          = $clog2(TOTAL_SUBLINES);
    localparam int ANG_W          = $clog2(ANGLES);
    localparam int SUB_W          = $clog2(SUBLINES + 1);
    localparam int ANG_THIRD      = ANGLES / 3;
    localparam int ANG_TWO_THIRDS = 2 * ANGLES / 3;

    localparam logic [7:0] GREY_DIM  = 8'd6;
    localparam logic [7:0] GREY_MID  = 8'd35;
    localparam logic [7:0] GREY_HIGH = 8'd60;

    localparam logic [2:0] LEVEL_OFF  = 3'd0;
    localparam logic [2:0] LEVEL_DIM  = 3'd1;
    localparam logic [2:0] LEVEL_MID  = 3'd2;
    localparam logic [2:0] LEVEL_FULL = 3'd7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [2:0] RING_BYTE [MAPPED_RINGS] = '{
        3'd0, 3'd3, 3'd0, 3'd3, 3'd0, 3'd3, 3'd0, 3'd3,
        3'd0, 3'd4, 3'd0, 3'd4, 3'd0, 3'd4, 3'd0, 3'd4,
        3'd1, 3'd4, 3'd1, 3'd4, 3'd1, 3'd4, 3'd1, 3'd4,
        3'd1, 3'd5, 3'd1, 3'd5, 3'd1, 3'd5, 3'd1, 3'd5,
        3'd2, 3'd5, 3'd2, 3'd5, 3'd2, 3'd5, 3'd2, 3'd5,
        3'd2, 3'd6, 3'd2, 3'd6, 3'd2, 3'd6, 3'd2, 3'd6,
        3'd3, 3'd6, 3'd3, 3'd6, 3'd3, 3'd6, 3'd3, 3'd6
    };

    localparam logic [2:0] RING_BIT [MAPPED_RINGS] = '{
        3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7,
        3'd4, 3'd0, 3'd5, 3'd1, 3'd6, 3'd2, 3'd7, 3'd3,
        3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7,
        3'd4, 3'd0, 3'd5, 3'd1, 3'd6, 3'd2, 3'd7, 3'd3,
        3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7,
        3'd4, 3'd0, 3'd5, 3'd1, 3'd6, 3'd2, 3'd7, 3'd3,
        3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7
    };

    typedef struct packed {
        logic       ok;
        logic [2:0] level;
        logic [2:0] byte_idx;
        logic [2:0] bit_idx;
    } pix_t;

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

endpackage

/* design/plw_line_ram.sv */
// plw_line_ram: simple dual-port line memory, one write and one registered read port
// generic; sized by its parameters only
`timescale 1ns / 1ps

module plw_line_ram #(
    parameter int DEPTH = 1680,
    parameter int WIDTH = 56,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/plw_pixel_map.sv */
// plw_pixel_map: ring thinning, grey contrast level and led byte/bit placement
// depends on plw_pkg
`timescale 1ns / 1ps

module plw_pixel_map (
    input  logic [5:0]    ring,
    input  logic [7:0]    angle,
    input  logic [3:0]    red,
    input  logic [3:0]    green,
    input  logic [3:0]    blue,
    output plw_pkg::pix_t pix
);

    localparam logic [15:0] RECIP_5 = 16'd205;
    localparam logic [15:0] RECIP_3 = 16'd171;

    logic [15:0] prod5;
    logic [15:0] prod3;
    logic [7:0]  q20;
    logic [7:0]  q10;
    logic [7:0]  q6;
    logic [7:0]  q3;
    logic        nz20;
    logic        nz10;
    logic        nz6;
    logic        nz3;
    logic        nz2;
    logic        thin;
    logic [7:0]  grey;
    logic [2:0]  level;
    logic        in_range;
    logic [5:0]  tab_idx;

    // reciprocal quotients, exact for 8-bit angles
    assign prod5 = 16'(angle) * RECIP_5;
    assign prod3 = 16'(angle) * RECIP_3;
    assign q20   = 8'(prod5 >> 12);
    assign q10   = 8'(prod5 >> 11);
    assign q6    = 8'(prod3 >> 10);
    assign q3    = 8'(prod3 >> 9);
    assign nz20  = angle != 8'(q20 * 8'd20);
    assign nz10  = angle != 8'(q10 * 8'd10);
    assign nz6   = angle != 8'(q6 * 8'd6);
    assign nz3   = angle != 8'(q3 * 8'd3);
    assign nz2   = angle[0];

    always_comb
    begin
        priority if (ring == 6'd0)
            thin = nz20;
        else if (ring == 6'd1)
            thin = nz10;
        else if (ring == 6'd2)
            thin = nz6;
        else if (ring == 6'd3 || ring == 6'd4)
            thin = nz3;
        else if (ring == 6'd5 || ring == 6'd6)
            thin = nz2;
        else
            thin = 1'b0;
    end

    assign grey = 8'(red) * 8'd3 + 8'(green) * 8'd6 + 8'(blue);

    always_comb
    begin
        priority if (thin || grey < plw_pkg::GREY_DIM)
            level = plw_pkg::LEVEL_OFF;
        else if (grey < plw_pkg::GREY_MID)
            level = plw_pkg::LEVEL_DIM;
        else if (grey < plw_pkg::GREY_HIGH)
            level = plw_pkg::LEVEL_MID;
        else
            level = plw_pkg::LEVEL_FULL;
    end

    assign in_range = (32'(ring) < 32'(plw_pkg::RINGS))
                   && (32'(ring) < 32'(plw_pkg::MAPPED_RINGS))
                   && (32'(angle) < 32'(plw_pkg::ANGLES));
    assign tab_idx  = in_range ? ring : 6'd0;

    assign pix.ok       = in_range;
    assign pix.level    = level;
    assign pix.byte_idx = plw_pkg::RING_BYTE[tab_idx];
    assign pix.bit_idx  = plw_pkg::RING_BIT[tab_idx];

endmodule

/* design/polar_led_line_pixel_writer.sv */
// polar_led_line_pixel_writer: top level, sequencer around the line memory
// depends on plw_pkg, plw_pixel_map, plw_line_ram
//
//   channel   signals                                          handshake
//   command   op ring angle red green blue subline byte_sel    start, busy
//   result    read_data                                        done (one-cycle strobe)
//
// a pixel write does seven subline read-modify-writes through the one memory, busy high,
// each subline written while the next one is read
// a byte read goes through ST_READ, which registers read_data and raises done with it
// after reset the start pattern is swept into all 1680 rows of memory, busy high
// results cannot be stalled; an out-of-range write is dropped, busy stays low
`timescale 1ns / 1ps

module polar_led_line_pixel_writer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       op,
    input  logic [5:0] ring,
    input  logic [7:0] angle,
    input  logic [3:0] red,
    input  logic [3:0] green,
    input  logic [3:0] blue,
    input  logic [10:0] subline,
    input  logic [2:0] byte_sel,
    output logic       done,
    output logic [7:0] read_data
);

    localparam int ROW_W    = plw_pkg::ROW_W;
    localparam int ROW_BITS = plw_pkg::ROW_BITS;
    localparam int ANG_W    = plw_pkg::ANG_W;
    localparam int SUB_W    = plw_pkg::SUB_W;

    plw_pkg::state_t state_reg, state_next;
    plw_pkg::pix_t   pix;
    plw_pkg::pix_t   pix_reg;

    logic [ROW_W-1:0]    init_row_reg, init_row_next;
    logic [ANG_W-1:0]    init_ang_reg, init_ang_next;
    logic [SUB_W-1:0]    init_sub_reg, init_sub_next;
    logic [SUB_W-1:0]    cnt_reg, cnt_next;
    logic [ROW_W-1:0]    rd_row_reg, rd_row_next;
    logic [ROW_W-1:0]    wr_row_reg;
    logic [2:0]          sel_reg;
    logic                rd_ok_reg, rd_ok_next;
    logic                done_reg, done_next;
    logic [7:0]          read_data_reg;

    logic                accept;
    logic                init_lit;
    logic                ram_wr_en;
    logic [ROW_W-1:0]    ram_wr_addr;
    logic [ROW_BITS-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [ROW_W-1:0]    ram_rd_addr;
    logic [ROW_BITS-1:0] ram_rd_data;
    logic [ROW_BITS-1:0] modified;
    logic [5:0]          bit_pos;

    plw_pixel_map u_map (
        .ring  (ring),
        .angle (angle),
        .red   (red),
        .green (green),
        .blue  (blue),
        .pix   (pix)
    );

    plw_line_ram #(
        .DEPTH (plw_pkg::TOTAL_SUBLINES),
        .WIDTH (ROW_BITS),
        .AW    (ROW_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign busy   = state_reg != plw_pkg::ST_IDLE;
    assign accept = start && !busy;

    assign init_lit = (32'(init_ang_reg) >= 32'(plw_pkg::ANG_TWO_THIRDS))
                   || ((32'(init_ang_reg) >= 32'(plw_pkg::ANG_THIRD))
                       && (init_sub_reg == SUB_W'(2) || init_sub_reg == SUB_W'(4)));

    assign bit_pos = {pix_reg.byte_idx, pix_reg.bit_idx};

    always_comb
    begin
        modified          = ram_rd_data;
        modified[bit_pos] = cnt_reg <= SUB_W'(pix_reg.level);
    end

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_row_reg;
        ram_wr_data = modified;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_row_reg;
        unique case (state_reg)
            plw_pkg::ST_INIT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = init_row_reg;
                ram_wr_data = {ROW_BITS{init_lit}};
            end
            plw_pkg::ST_IDLE:
            begin
                ram_rd_en   = accept && op == plw_pkg::OP_READ;
                ram_rd_addr = ROW_W'(subline);
            end
            plw_pkg::ST_WRITE:
            begin
                ram_rd_en = cnt_reg < SUB_W'(plw_pkg::SUBLINES);
                ram_wr_en = cnt_reg != '0;
            end
            plw_pkg::ST_READ:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        init_row_next = init_row_reg;
        init_ang_next = init_ang_reg;
        init_sub_next = init_sub_reg;
        cnt_next      = cnt_reg;
        rd_row_next   = rd_row_reg;
        rd_ok_next    = rd_ok_reg;
        done_next     = 1'b0;
        unique case (state_reg)
            plw_pkg::ST_INIT:
            begin
                init_row_next = init_row_reg + ROW_W'(1);
                if (init_sub_reg == SUB_W'(plw_pkg::SUBLINES - 1))
                begin
                    init_sub_next = '0;
                    init_ang_next = init_ang_reg + ANG_W'(1);
                end
                else
                begin
                    init_sub_next = init_sub_reg + SUB_W'(1);
                end
                if (init_row_reg == ROW_W'(plw_pkg::TOTAL_SUBLINES - 1))
                begin
                    state_next = plw_pkg::ST_IDLE;
                end
            end
            plw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == plw_pkg::OP_READ)
                    begin
                        rd_ok_next = (32'(subline) < 32'(plw_pkg::TOTAL_SUBLINES))
                                  && (32'(byte_sel) < 32'(plw_pkg::LINE_BYTES));
                        state_next = plw_pkg::ST_READ;
                    end
                    else if (pix.ok)
                    begin
                        cnt_next    = '0;
                        rd_row_next = ROW_W'(32'(angle) * 32'(plw_pkg::SUBLINES));
                        state_next  = plw_pkg::ST_WRITE;
                    end
                end
            end
            plw_pkg::ST_WRITE:
            begin
                cnt_next    = cnt_reg + SUB_W'(1);
                rd_row_next = rd_row_reg + ROW_W'(1);
                if (cnt_reg == SUB_W'(plw_pkg::SUBLINES))
                begin
                    state_next = plw_pkg::ST_IDLE;
                end
            end
            plw_pkg::ST_READ:
            begin
                done_next  = 1'b1;
                state_next = plw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = plw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= plw_pkg::ST_INIT;
            init_row_reg <= '0;
            init_ang_reg <= '0;
            init_sub_reg <= '0;
            cnt_reg      <= '0;
            rd_row_reg   <= '0;
            rd_ok_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_row_reg <= init_row_next;
            init_ang_reg <= init_ang_next;
            init_sub_reg <= init_sub_next;
            cnt_reg      <= cnt_next;
            rd_row_reg   <= rd_row_next;
            rd_ok_reg    <= rd_ok_next;
            done_reg     <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wr_row_reg <= rd_row_reg;
        if (accept)
        begin
            pix_reg <= pix;
            sel_reg <= byte_sel;
        end
        if (state_reg == plw_pkg::ST_READ)
        begin
            read_data_reg <= rd_ok_reg ? ram_rd_data[{sel_reg, 3'b000} +: 8] : 8'd0;
        end
    end

    assign done      = done_reg;
    assign read_data = read_data_reg;

endmodule

/* design/plw_checker.sv */
// plw_checker: port-level checks of the polar led line pixel writer, with its bind
// depends on polar_led_line_pixel_writer ports only
`timescale 1ns / 1ps

module plw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       op,
    input logic [2:0] byte_sel,
    input logic       done,
    input logic [7:0] read_data
);

    logic rd_xfer;

    assign rd_xfer = start && !busy && op;

    // every read transfer yields a result
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        rd_xfer |-> ##2 done)
        else $error("read transfer without result");

    // no result without a read transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(rd_xfer, 2))
        else $error("result without read transfer");

    // a read holds the command side off while it is in flight
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rd_xfer |=> busy)
        else $error("read transfer did not raise busy");

    // out-of-range byte reads as zero
    a_bad_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_xfer && byte_sel == 3'd7) |-> ##2 (read_data == 8'd0))
        else $error("out-of-range byte read not zero");

endmodule

bind polar_led_line_pixel_writer plw_checker u_plw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .byte_sel  (byte_sel),
    .done      (done),
    .read_data (read_data)
);

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench of polar_led_line_pixel_writer, directed table then random transfers
// depends on plw_pkg and the design top level; the line store is predicted inside the bench
`timescale 1ns / 1ps

module tb_top;

    localparam int STORE_BYTES    = plw_pkg::TOTAL_SUBLINES * plw_pkg::LINE_BYTES;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic        op;
        logic [5:0]  ring;
        logic [7:0]  angle;
        logic [3:0]  red;
        logic [3:0]  green;
        logic [3:0]  blue;
        logic [10:0] subline;
        logic [2:0]  byte_sel;
        bit          has_fixed;
        logic [7:0]  fixed_byte;
    } cmd_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        start    = 1'b0;
    logic        op       = plw_pkg::OP_WRITE;
    logic [5:0]  ring     = '0;
    logic [7:0]  angle    = '0;
    logic [3:0]  red      = '0;
    logic [3:0]  green    = '0;
    logic [3:0]  blue     = '0;
    logic [10:0] subline  = '0;
    logic [2:0]  byte_sel = '0;
    logic        busy;
    logic        done;
    logic [7:0]  read_data;

    logic [7:0]  line_mem [STORE_BYTES];
    logic [7:0]  pending_bytes [$];
    cmd_t        directed_rows [$];
    int          err_count  = 0;
    int          idle_count = 0;
    logic [7:0]  hot_angle  = 8'd0;

    polar_led_line_pixel_writer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .ring      (ring),
        .angle     (angle),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .subline   (subline),
        .byte_sel  (byte_sel),
        .done      (done),
        .read_data (read_data)
    );

    always #10 clk = ~clk;

    task automatic load_start_pattern();
        bit lit;
        for (int a = 0; a < plw_pkg::ANGLES; a++)
        begin
            for (int s = 0; s < plw_pkg::SUBLINES; s++)
            begin
                lit = (a >= 2 * plw_pkg::ANGLES / 3)
                   || (a >= plw_pkg::ANGLES / 3 && (s == 2 || s == 4));
                for (int b = 0; b < plw_pkg::LINE_BYTES; b++)
                    line_mem[(a * plw_pkg::SUBLINES + s) * plw_pkg::LINE_BYTES + b] =
                        lit ? 8'hFF : 8'h00;
            end
        end
    endtask

    function automatic bit ring_thinned(int r, int a);
        if (r == 0)
            return (a % 20) != 0;
        if (r == 1)
            return (a % 10) != 0;
        if (r == 2)
            return (a % 6) != 0;
        if (r == 3 || r == 4)
            return (a % 3) != 0;
        if (r == 5 || r == 6)
            return (a % 2) != 0;
        return 1'b0;
    endfunction

    function automatic int contrast_level(logic [3:0] r, logic [3:0] g, logic [3:0] b);
        int grey;
        grey = int'(r) * 3 + int'(g) * 6 + int'(b);
        if (grey > 70)
            grey = 70;
        if (grey < 6)
            return 0;
        if (grey < 35)
            return 1;
        if (grey < 60)
            return 2;
        return 7;
    endfunction

    task automatic apply_pixel_write(cmd_t c);
        int r;
        int a;
        int lvl;
        int byte_pos;
        int bit_pos;
        r = int'(c.ring);
        a = int'(c.angle);
        if (r >= plw_pkg::RINGS || r >= 56 || a >= plw_pkg::ANGLES)
            return;
        lvl      = ring_thinned(r, a) ? 0 : contrast_level(c.red, c.green, c.blue);
        byte_pos = (r % 2 == 0) ? r / 16 : 3 + (r + 7) / 16;
        bit_pos  = (((r / 8) + r) % 2) * 4 + (r % 8) / 2;
        for (int s = 0; s < plw_pkg::SUBLINES; s++)
            line_mem[(a * plw_pkg::SUBLINES + s) * plw_pkg::LINE_BYTES + byte_pos][bit_pos] =
                (s < lvl);
    endtask

    function automatic logic [7:0] lookup_line_byte(logic [10:0] sl, logic [2:0] b);
        if (int'(sl) >= plw_pkg::TOTAL_SUBLINES || int'(b) >= plw_pkg::LINE_BYTES)
            return 8'h00;
        return line_mem[int'(sl) * plw_pkg::LINE_BYTES + int'(b)];
    endfunction

    function automatic cmd_t wr(int r, int a, int rd_v, int gr_v, int bl_v);
        cmd_t c;
        c = '{op: plw_pkg::OP_WRITE, ring: 6'(r), angle: 8'(a), red: 4'(rd_v),
              green: 4'(gr_v), blue: 4'(bl_v), subline: '0, byte_sel: '0,
              has_fixed: 1'b0, fixed_byte: '0};
        return c;
    endfunction

    function automatic cmd_t rd(int sl, int b, bit has_fixed, int fixed_byte);
        cmd_t c;
        c = '{op: plw_pkg::OP_READ, ring: '0, angle: '0, red: '0, green: '0, blue: '0,
              subline: 11'(sl), byte_sel: 3'(b), has_fixed: has_fixed,
              fixed_byte: 8'(fixed_byte)};
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int pick;
        c.op         = 1'($urandom);
        c.ring       = 6'($urandom);
        c.angle      = 8'($urandom);
        c.red        = 4'($urandom);
        c.green      = 4'($urandom);
        c.blue       = 4'($urandom);
        c.subline    = 11'($urandom);
        c.byte_sel   = 3'($urandom);
        c.has_fixed  = 1'b0;
        c.fixed_byte = '0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            c.op = plw_pkg::OP_WRITE;
            pick = $urandom_range(0, 99);
            if (pick < 25)
                c.ring = 6'($urandom_range(0, 6));
            else if (pick < 90)
                c.ring = 6'($urandom_range(0, 55));
            else
                c.ring = 6'($urandom_range(56, 63));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                c.angle = hot_angle;
            else if (pick < 94)
                c.angle = 8'($urandom_range(0, plw_pkg::ANGLES - 1));
            else
                c.angle = 8'($urandom_range(plw_pkg::ANGLES, 255));
        end
        else
        begin
            c.op = plw_pkg::OP_READ;
            if ($urandom_range(0, 99) < 80)
            begin
                c.subline  = 11'(int'(hot_angle) * plw_pkg::SUBLINES
                                 + $urandom_range(0, plw_pkg::SUBLINES - 1));
                c.byte_sel = 3'($urandom_range(0, plw_pkg::LINE_BYTES - 1));
            end
        end
        return c;
    endfunction

    // caller is at a rising edge; returns at the edge that accepts the transfer
    task automatic drive_cmd(cmd_t c);
        op       <= c.op;
        ring     <= c.ring;
        angle    <= c.angle;
        red      <= c.red;
        green    <= c.green;
        blue     <= c.blue;
        subline  <= c.subline;
        byte_sel <= c.byte_sel;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (c.op == plw_pkg::OP_READ)
            pending_bytes.push_back(c.has_fixed ? c.fixed_byte
                                                : lookup_line_byte(c.subline, c.byte_sel));
        else
            apply_pixel_write(c);
    endtask

    task automatic sender_gap(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t mismatch %s: expected %02h actual %02h", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && done !== 1'b0)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch("read_data, no read waiting", 8'hxx, read_data);
            else
            begin
                want = pending_bytes.pop_front();
                if (read_data !== want)
                    report_mismatch("read_data", want, read_data);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("** polar_led_line_pixel_writer: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int idle_pct [4];
        int phase;
        idle_pct = '{0, 54, 0, 21};
        load_start_pattern();

        // start pattern and range limits
        directed_rows.push_back(rd(0, 0, 1, 8'h00));
        directed_rows.push_back(rd(562, 3, 1, 8'hFF));
        directed_rows.push_back(rd(563, 0, 1, 8'h00));
        directed_rows.push_back(rd(1679, 6, 1, 8'hFF));
        directed_rows.push_back(rd(1680, 0, 1, 8'h00));
        directed_rows.push_back(rd(2047, 7, 1, 8'h00));
        directed_rows.push_back(wr(63, 200, 0, 0, 0));
        directed_rows.push_back(wr(8, 255, 0, 0, 0));
        directed_rows.push_back(rd(1400, 3, 1, 8'hFF));
        // inner ring thinning, kept and dropped
        directed_rows.push_back(wr(0, 20, 15, 15, 15));
        directed_rows.push_back(rd(146, 0, 1, 8'h01));
        directed_rows.push_back(wr(0, 161, 15, 15, 15));
        directed_rows.push_back(rd(1127, 0, 1, 8'hFE));
        // outermost ring, contrast edges
        directed_rows.push_back(wr(55, 239, 0, 0, 5));
        directed_rows.push_back(rd(1679, 6, 1, 8'h7F));
        directed_rows.push_back(wr(55, 239, 0, 0, 6));
        directed_rows.push_back(rd(1673, 6, 1, 8'hFF));
        directed_rows.push_back(wr(7, 100, 0, 4, 10));
        directed_rows.push_back(wr(9, 100, 0, 5, 5));
        directed_rows.push_back(wr(11, 100, 3, 8, 2));
        directed_rows.push_back(wr(13, 100, 0, 10, 0));
        directed_rows.push_back(wr(15, 101, 0, 10, 10));
        directed_rows.push_back(rd(701, 4, 0, 0));
        directed_rows.push_back(rd(700, 3, 0, 0));
        directed_rows.push_back(wr(2, 102, 15, 15, 15));
        directed_rows.push_back(wr(5, 103, 15, 15, 15));
        directed_rows.push_back(rd(720, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            drive_cmd(directed_rows[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase = (i * 4) / RANDOM_ITEMS;
            if (i % 20 == 0)
                hot_angle = ($urandom_range(0, 3) == 0)
                    ? 8'(60 * $urandom_range(0, 3))
                    : 8'($urandom_range(0, plw_pkg::ANGLES - 1));
            sender_gap(idle_pct[phase]);
            drive_cmd(random_cmd());
        end
        start <= 1'b0;

        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && pending_bytes.size() == 0)
            $display("** polar_led_line_pixel_writer: PASSED **");
        else
            $display("** polar_led_line_pixel_writer: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
design/plw_pkg.sv
design/plw_line_ram.sv
design/plw_pixel_map.sv
design/polar_led_line_pixel_writer.sv
design/plw_checker.sv
tb/sv/tb_top.sv
